>>> hdl/sefc_pkg.sv
// shared constants, types and command bundles for the source energy false-colour map
package sefc_pkg;

    // frame geometry
    localparam int SOURCES  = 1024;
    localparam int SAMPLES  = 8;
    localparam int SRC_W    = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int SAMP_W   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

    // field and datapath widths
    localparam int SAMPLE_W  = 16;
    localparam int INDEX_W   = 10;
    localparam int IDX_EXT_W = 13;
    localparam int MAG_W     = 17;
    localparam int ENERGY_W  = 34;
    localparam int E10_W     = 38;
    localparam int M3_W      = 36;
    localparam int COLOR_W   = 17;

    // divider sequencing: one quotient bit per step
    localparam int DIV_STEPS = COLOR_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // colour constants in Q1.16
    localparam logic [COLOR_W-1:0] ONE_Q16    = 17'd65536;
    localparam logic [COLOR_W-1:0] POINT3_Q16 = 17'd19661;

    // operation codes
    typedef enum logic
    {
        OP_PUSH = 1'b0,
        OP_READ = 1'b1
    } sefc_op_t;

    // commands from the controller to the datapath
    typedef struct packed
    {
        logic push_take;
        logic read_take;
        logic push_do;
        logic load;
        logic div_step;
        logic div_first;
        logic finish;
    } sefc_cmd_t;

    // status from the datapath to the controller
    typedef struct packed
    {
        logic out_valid;
        logic out_stall;
    } sefc_status_t;

endpackage

>>> hdl/sefc_ram.sv
// generic single-write, single-read memory with registered read data
module sefc_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/sefc_ctrl.sv
// controller: sequences push, fetch, bit-serial divide and result hand-off
module sefc_ctrl
    import sefc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [0:0]   operation,
    input  sefc_status_t status,
    output logic         in_stall,
    output sefc_cmd_t    cmd
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_PUSH,
        S_LOAD,
        S_DIV,
        S_DONE
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == OP_READ)
                    begin
                        cmd.read_take = 1'b1;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        cmd.push_take = 1'b1;
                        state_next    = S_PUSH;
                    end
                end
            end
            S_PUSH:
            begin
                cmd.push_do = 1'b1;
                state_next  = S_IDLE;
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (cnt_reg == '0);
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!(status.out_valid && status.out_stall))
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // divider never runs past its last quotient bit
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg <= CNT_W'(DIV_STEPS - 1))
        else $error("divide step count overran");

    // a result is only produced into a free or draining output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(status.out_valid && status.out_stall))
        else $error("result written over a stalled beat");

    // the divide state always follows a load directly, with the step counter at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_DIV && cnt_reg == '0)
        else $error("divide did not start after load");

endmodule

>>> hdl/sefc_dp.sv
// datapath: energy accumulation, energy store, frame maximum, divider and colour map
module sefc_dp
    import sefc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  sefc_cmd_t                  cmd,
    input  logic signed [SAMPLE_W-1:0] sample_value,
    input  logic [INDEX_W-1:0]         source_index,
    input  logic                       out_stall,
    output sefc_status_t               status,
    output logic                       out_valid,
    output logic [COLOR_W-1:0]         red,
    output logic [COLOR_W-1:0]         green,
    output logic [COLOR_W-1:0]         blue,
    output logic [COLOR_W-1:0]         norm_energy
);

    // accumulation state
    logic [ENERGY_W-1:0] sq_reg;
    logic [ENERGY_W-1:0] acc_reg;
    logic [ENERGY_W-1:0] max_reg;
    logic [SAMP_W-1:0]   samp_pos_reg;
    logic [SRC_W-1:0]    src_pos_reg;

    // read and divide state
    logic                in_range_reg;
    logic [ENERGY_W-1:0] e_reg;
    logic [ENERGY_W-1:0] m_reg;
    logic [E10_W-1:0]    e10_reg;
    logic [M3_W-1:0]     m3_reg;
    logic [ENERGY_W-1:0] rem_reg;
    logic [COLOR_W-1:0]  quo_reg;

    // output register
    logic                out_valid_reg;
    logic [COLOR_W-1:0]  red_reg;
    logic [COLOR_W-1:0]  green_reg;
    logic [COLOR_W-1:0]  blue_reg;
    logic [COLOR_W-1:0]  norm_reg;

    logic [MAG_W-1:0]     mag;
    logic [ENERGY_W-1:0]  sq_next;
    logic [ENERGY_W-1:0]  acc_base;
    logic [ENERGY_W:0]    acc_sum;
    logic [ENERGY_W-1:0]  acc_new;
    logic [ENERGY_W-1:0]  max_base;
    logic [ENERGY_W-1:0]  max_next;
    logic                 last_sample;
    logic                 last_source;
    logic                 frame_start;
    logic [IDX_EXT_W-1:0] idx_ext;
    logic                 idx_in_range;
    logic [ENERGY_W-1:0]  rd_data;
    logic [ENERGY_W-1:0]  e_load;
    logic [ENERGY_W:0]    div_cand;
    logic                 div_ge;
    logic [ENERGY_W:0]    div_diff;
    logic [COLOR_W-1:0]   red_next;
    logic [COLOR_W-1:0]   green_next;
    logic [COLOR_W-1:0]   blue_next;
    logic [COLOR_W-1:0]   norm_next;

    // magnitude and square of the incoming sample
    always_comb
    begin
        if (sample_value[SAMPLE_W-1])
        begin
            mag = MAG_W'(0) - {1'b1, sample_value};
        end
        else
        begin
            mag = {1'b0, sample_value};
        end
        sq_next = ENERGY_W'({17'd0, mag} * {17'd0, mag});
    end

    // saturating accumulation and frame maximum
    always_comb
    begin
        last_sample = (samp_pos_reg == SAMP_W'(SAMPLES - 1));
        last_source = (src_pos_reg == SRC_W'(SOURCES - 1));
        frame_start = (samp_pos_reg == '0) && (src_pos_reg == '0);
        acc_base    = (samp_pos_reg == '0) ? '0 : acc_reg;
        acc_sum     = {1'b0, acc_base} + {1'b0, sq_reg};
        acc_new     = acc_sum[ENERGY_W] ? '1 : acc_sum[ENERGY_W-1:0];
        max_base    = frame_start ? '0 : max_reg;
        max_next    = (last_sample && (acc_new > max_base)) ? acc_new : max_base;
    end

    // read address and range check
    assign idx_ext      = IDX_EXT_W'(source_index);
    assign idx_in_range = (idx_ext < IDX_EXT_W'(SOURCES));

    sefc_ram #(
        .WIDTH (ENERGY_W),
        .DEPTH (SOURCES)
    ) u_energy_store (
        .clk     (clk),
        .wr_en   (cmd.push_do && last_sample),
        .wr_addr (src_pos_reg),
        .wr_data (acc_new),
        .rd_en   (cmd.read_take),
        .rd_addr (idx_ext[SRC_W-1:0]),
        .rd_data (rd_data)
    );

    assign e_load = in_range_reg ? rd_data : '0;

    // one restoring divide step
    always_comb
    begin
        div_cand = cmd.div_first ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        div_ge   = (div_cand >= {1'b0, m_reg});
        div_diff = div_cand - {1'b0, m_reg};
    end

    // colour decision from exact band comparisons
    always_comb
    begin
        red_next   = ONE_Q16;
        green_next = ONE_Q16;
        blue_next  = ONE_Q16;
        norm_next  = '0;
        priority if ((m_reg == '0) || (e_reg == '0))
        begin
            norm_next = '0;
        end
        else if (e_reg > m_reg)
        begin
            norm_next = ONE_Q16;
        end
        else if (e10_reg <= E10_W'(m3_reg))
        begin
            norm_next  = quo_reg;
            red_next   = '0;
            green_next = '0;
            blue_next  = ONE_Q16 - quo_reg;
        end
        else if (e10_reg <= E10_W'({m3_reg, 1'b0}))
        begin
            norm_next  = quo_reg;
            red_next   = '0;
            green_next = quo_reg + POINT3_Q16;
            blue_next  = '0;
        end
        else
        begin
            norm_next  = quo_reg;
            red_next   = quo_reg;
            green_next = '0;
            blue_next  = '0;
        end
    end

    // control state of the accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            max_reg      <= '0;
            samp_pos_reg <= '0;
            src_pos_reg  <= '0;
        end
        else if (cmd.push_do)
        begin
            acc_reg <= acc_new;
            max_reg <= max_next;
            if (last_sample)
            begin
                samp_pos_reg <= '0;
                src_pos_reg  <= last_source ? '0 : src_pos_reg + 1'b1;
            end
            else
            begin
                samp_pos_reg <= samp_pos_reg + 1'b1;
            end
        end
    end

    // output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.push_take)
        begin
            sq_reg <= sq_next;
        end
        if (cmd.read_take)
        begin
            in_range_reg <= idx_in_range;
        end
        if (cmd.load)
        begin
            e_reg   <= e_load;
            m_reg   <= max_reg;
            rem_reg <= e_load;
            e10_reg <= E10_W'({e_load, 3'b000}) + E10_W'({e_load, 1'b0});
            m3_reg  <= M3_W'({max_reg, 1'b0}) + M3_W'(max_reg);
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_ge ? div_diff[ENERGY_W-1:0] : div_cand[ENERGY_W-1:0];
            quo_reg <= {quo_reg[COLOR_W-2:0], div_ge};
        end
        if (cmd.finish)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            norm_reg  <= norm_next;
        end
    end

    assign status.out_valid = out_valid_reg;
    assign status.out_stall = out_stall;
    assign out_valid        = out_valid_reg;
    assign red              = red_reg;
    assign green            = green_reg;
    assign blue             = blue_reg;
    assign norm_energy      = norm_reg;

    // normalised energy never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> norm_reg <= ONE_Q16)
        else $error("normalised energy above one");

    // a beat is white or has at most one lit channel
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            (red_reg == ONE_Q16 && green_reg == ONE_Q16 && blue_reg == ONE_Q16) ||
            ($countones({red_reg != '0, green_reg != '0, blue_reg != '0}) <= 1))
        else $error("colour beat mixes channels");

    // a finished source never exceeds the frame maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_do && last_sample |=> max_reg >= $past(acc_new))
        else $error("frame maximum below a stored energy");

endmodule

>>> hdl/source_energy_false_color_map.sv
// top level of the source energy false-colour map
//
// input channel: in_valid / in_stall carry one beat of operation, sample_value
// and source_index. a push beat adds the square of one sample to the current
// source; after the last sample of a source its energy goes to the energy
// store and the frame maximum is updated. the first push of a frame clears
// the maximum. a push raises in_stall while it is applied and gives no output beat.
// a read beat fetches one stored energy, divides it by the frame maximum with
// a restoring divider giving one quotient bit a cycle, and maps the quotient
// to red, green, blue and norm_energy in Q1.16.
// read path: the fetch overlaps acceptance, then the load stage, the 17 divide
// steps and the result stage lead to out_valid; no new beat is accepted until
// the result stage has run, and that stage waits while a held result is stalled.
// output channel: out_valid / out_stall; a result held by out_stall stays in
// the output register while pushes and the next read proceed, and a finished
// read waits until the register drains.
// reset clears positions, accumulator, maximum and control; the energy store
// is not cleared and needs no clearing pass.
module source_energy_false_color_map
    import sefc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [0:0]                 operation,
    input  logic signed [SAMPLE_W-1:0] sample_value,
    input  logic [INDEX_W-1:0]         source_index,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [COLOR_W-1:0]         red,
    output logic [COLOR_W-1:0]         green,
    output logic [COLOR_W-1:0]         blue,
    output logic [COLOR_W-1:0]         norm_energy
);

    sefc_cmd_t    cmd;
    sefc_status_t status;

    // sequencer
    sefc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .status    (status),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    // arithmetic and storage
    sefc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sample_value (sample_value),
        .source_index (source_index),
        .out_stall    (out_stall),
        .status       (status),
        .out_valid    (out_valid),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .norm_energy  (norm_energy)
    );

endmodule

>>> tb/tb_source_energy_false_color_map.sv
// self-checking testbench for the source energy false-colour map
`timescale 1ns / 100ps

module tb_source_energy_false_color_map;
    import sefc_pkg::*;

    localparam int                CLK_HALF     = 5;
    localparam int                RESET_CYCLES = 8;
    localparam int                DRAIN_SLACK  = 40;
    localparam int                LONG_HOLD    = 400;
    localparam int                MAX_PRINTED  = 40;
    localparam longint unsigned   ENERGY_CEIL  = (64'd1 << ENERGY_W) - 64'd1;

    // one colour beat as it leaves the block
    typedef struct packed
    {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] level;
    } colour_t;

    // one line of the directed table; reps repeats the same beat
    typedef struct
    {
        sefc_op_t                   op;
        logic signed [SAMPLE_W-1:0] value;
        int                         reps;
        logic [INDEX_W-1:0]         index;
        bit                         typed;
        colour_t                    want;
    } stim_row_t;

    localparam colour_t WHITE_ZERO = '{red: ONE_Q16, green: ONE_Q16, blue: ONE_Q16, level: '0};
    localparam colour_t FULL_RED   = '{red: ONE_Q16, green: '0, blue: '0, level: ONE_Q16};
    localparam colour_t NO_COLOUR  = '0;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [0:0]                 operation;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [INDEX_W-1:0]         source_index;
    logic                       out_valid;
    logic                       out_stall;
    logic [COLOR_W-1:0]         red;
    logic [COLOR_W-1:0]         green;
    logic [COLOR_W-1:0]         blue;
    logic [COLOR_W-1:0]         norm_energy;

    // predictor state
    logic [ENERGY_W-1:0] energy_mem [SOURCES];
    logic [ENERGY_W-1:0] energy_sum;
    logic [ENERGY_W-1:0] peak_energy;
    int unsigned         sample_pos;
    int unsigned         source_pos;
    int                  frame_wraps;

    colour_t colour_expect_q [$];
    colour_t want_colour;

    int  mismatches;
    int  beats_sent;
    int  reads_sent;
    int  colours_checked;
    int  hits_blue;
    int  hits_green;
    int  hits_red;
    int  hits_white;
    int  burst_left;
    int  source_scale;
    logic hold_ask;

    // directed table: boundaries, extremes, zero energy and an undefined maximum
    stim_row_t directed_rows [0:20] = '{
        '{OP_PUSH, 16'sd0,      8, '0,    1'b0, NO_COLOUR},
        '{OP_READ, 16'sd0,      1, 10'd0, 1'b1, WHITE_ZERO},
        '{OP_PUSH, 16'sd100,    1, '0,    1'b0, NO_COLOUR},
        '{OP_PUSH, 16'sd0,      7, '0,    1'b0, NO_COLOUR},
        '{OP_READ, 16'sd0,      1, 10'd1, 1'b1, FULL_RED},
        '{OP_PUSH, 16'sd50,     1, '0,    1'b0, NO_COLOUR},
        '{OP_PUSH, -16'sd20,    1, '0,    1'b0, NO_COLOUR},
        '{OP_PUSH, 16'sd10,     1, '0,    1'b0, NO_COLOUR},
        '{OP_PUSH, 16'sd0,      5, '0,    1'b0, NO_COLOUR},
        '{OP_READ, 16'sd0,      1, 10'd2, 1'b0, NO_COLOUR},
        '{OP_PUSH, 16'sd70,     1, '0,    1'b0, NO_COLOUR},
        '{OP_PUSH, -16'sd30,    1, '0,    1'b0, NO_COLOUR},
        '{OP_PUSH, 16'sd10,     2, '0,    1'b0, NO_COLOUR},
        '{OP_PUSH, 16'sd0,      4, '0,    1'b0, NO_COLOUR},
        '{OP_READ, 16'sd0,      1, 10'd3, 1'b0, NO_COLOUR},
        '{OP_PUSH, 16'sd32767,  8, '0,    1'b0, NO_COLOUR},
        '{OP_PUSH, -16'sd32768, 8, '0,    1'b0, NO_COLOUR},
        '{OP_READ, 16'sd0,      1, 10'd5, 1'b1, FULL_RED},
        '{OP_READ, 16'sd0,      1, 10'd4, 1'b0, NO_COLOUR},
        '{OP_READ, 16'sd0,      1, 10'd2, 1'b0, NO_COLOUR},
        '{OP_READ, 16'sd0,      1, 10'd0, 1'b1, WHITE_ZERO}
    };

    source_energy_false_color_map u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .sample_value (sample_value),
        .source_index (source_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .norm_energy  (norm_energy)
    );

    // clock and the single reset pulse
    initial
    begin
        clk   = 1'b0;
        rst_n = 1'b0;
        fork
            forever #CLK_HALF clk = ~clk;
            begin
                repeat (RESET_CYCLES) @(posedge clk);
                rst_n <= 1'b1;
            end
        join_none
    end

    // one line per mismatch, printing capped
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < MAX_PRINTED)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // square one sample into the running source energy
    function automatic void accumulate_sample(input logic signed [SAMPLE_W-1:0] s);
        int              sv;
        longint unsigned mag;
        longint unsigned total;
        sv  = s;
        mag = (sv < 0) ? -sv : sv;
        if (sample_pos == 0 && source_pos == 0)
            peak_energy = '0;
        total = (sample_pos == 0) ? 64'd0 : 64'(energy_sum);
        total += mag * mag;
        if (total > ENERGY_CEIL)
            total = ENERGY_CEIL;
        energy_sum = total[ENERGY_W-1:0];
        if (sample_pos + 1 >= SAMPLES)
        begin
            energy_mem[source_pos] = energy_sum;
            if (energy_sum > peak_energy)
                peak_energy = energy_sum;
            sample_pos = 0;
            if (source_pos + 1 >= SOURCES)
            begin
                source_pos = 0;
                frame_wraps++;
            end
            else
                source_pos++;
        end
        else
            sample_pos++;
    endfunction

    // colour of one source against the current frame maximum
    function automatic colour_t colour_of(input logic [INDEX_W-1:0] idx);
        longint unsigned e;
        longint unsigned m;
        longint unsigned q;
        colour_t         c;
        e = 0;
        if (idx < SOURCES)
            e = energy_mem[idx];
        m = peak_energy;
        c = WHITE_ZERO;
        if (m != 0 && e != 0)
        begin
            if (e > m)
                c.level = ONE_Q16;
            else
            begin
                q       = (e << 16) / m;
                c.level = q[COLOR_W-1:0];
                if (10 * e <= 3 * m)
                begin
                    c.red   = '0;
                    c.green = '0;
                    c.blue  = ONE_Q16 - q[COLOR_W-1:0];
                end
                else if (10 * e <= 6 * m)
                begin
                    c.red   = '0;
                    c.green = q[COLOR_W-1:0] + POINT3_Q16;
                    c.blue  = '0;
                end
                else
                begin
                    c.red   = q[COLOR_W-1:0];
                    c.green = '0;
                    c.blue  = '0;
                end
            end
        end
        if (c.red == ONE_Q16 && c.green == ONE_Q16)
            hits_white++;
        else if (c.blue != 0)
            hits_blue++;
        else if (c.green != 0)
            hits_green++;
        else
            hits_red++;
        return c;
    endfunction

    // offer one beat in bursts with random gaps, then predict on acceptance
    task automatic send_beat(input sefc_op_t op, input logic signed [SAMPLE_W-1:0] val,
                             input logic [INDEX_W-1:0] idx, input bit typed,
                             input colour_t typed_colour);
        int      gap;
        colour_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        operation    <= op;
        sample_value <= val;
        source_index <= idx;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
        if (op == OP_READ)
        begin
            reads_sent++;
            predicted = colour_of(idx);
            colour_expect_q.insert(colour_expect_q.size(), typed ? typed_colour : predicted);
        end
        else
            accumulate_sample(val);
    endtask

    // random beat: pushes with a per-source scale, reads only of written entries
    task automatic random_beat(input int read_pct);
        int                         avail;
        logic signed [SAMPLE_W-1:0] val;
        avail = (frame_wraps > 0) ? SOURCES : int'(source_pos);
        if (avail > 0 && $urandom_range(0, 99) < read_pct)
            send_beat(OP_READ, SAMPLE_W'($urandom), INDEX_W'($urandom_range(0, avail - 1)),
                      1'b0, NO_COLOUR);
        else
        begin
            if (sample_pos == 0)
                source_scale = $urandom_range(0, 4);
            case (source_scale)
                0: val = SAMPLE_W'($urandom);
                1: val = SAMPLE_W'($urandom_range(0, 511) - 256);
                2: val = '0;
                3: val = SAMPLE_W'($urandom_range(0, 8191) - 4096);
                default:
                begin
                    val = SAMPLE_W'($urandom_range(28000, 32767));
                    if ($urandom_range(0, 1) == 1)
                        val = -val;
                end
            endcase
            send_beat(OP_PUSH, val, INDEX_W'($urandom), 1'b0, NO_COLOUR);
        end
    endtask

    // stop offering and wait for every outstanding colour plus a latency margin
    task automatic drain_results();
        in_valid <= 1'b0;
        while (colour_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // output stall pattern, with one long hold on request
    initial
    begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        bit hold_done;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ask && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 1) == 1);
                    2:       out_stall <= ($urandom_range(0, 7) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // compare each accepted colour beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            colours_checked++;
            if (colour_expect_q.size() == 0)
                report_mismatch("colour beat with nothing outstanding, red", red, 0);
            else
            begin
                want_colour = colour_expect_q.pop_front();
                if (red !== want_colour.red)
                    report_mismatch("red", red, want_colour.red);
                if (green !== want_colour.green)
                    report_mismatch("green", green, want_colour.green);
                if (blue !== want_colour.blue)
                    report_mismatch("blue", blue, want_colour.blue);
                if (norm_energy !== want_colour.level)
                    report_mismatch("norm_energy", norm_energy, want_colour.level);
            end
        end
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // stimulus
    initial
    begin
        in_valid     <= 1'b0;
        operation    <= OP_PUSH;
        sample_value <= '0;
        source_index <= '0;
        hold_ask     <= 1'b0;
        energy_sum   = '0;
        peak_energy  = '0;
        sample_pos   = 0;
        source_pos   = 0;
        frame_wraps  = 0;
        mismatches   = 0;
        beats_sent   = 0;
        reads_sent   = 0;
        colours_checked = 0;
        hits_blue    = 0;
        hits_green   = 0;
        hits_red     = 0;
        hits_white   = 0;
        burst_left   = 0;
        source_scale = 0;
        @(posedge rst_n);
        @(posedge clk);

        // directed table
        foreach (directed_rows[i])
            repeat (directed_rows[i].reps)
                send_beat(directed_rows[i].op, directed_rows[i].value, directed_rows[i].index,
                          directed_rows[i].typed, directed_rows[i].want);

        // random mix, receiver asked for a long hold so the block backs up
        hold_ask <= 1'b1;
        repeat (900) random_beat(30);

        // sender pause until everything has come back
        drain_results();

        // second random mix over the sources written so far
        repeat (940) random_beat(35);

        drain_results();
        $display("%0d beats sent, %0d colour reads, %0d colours checked, %0d sources filled",
                 beats_sent, reads_sent, colours_checked, source_pos);
        $display("bands predicted: blue %0d, green %0d, red %0d, white %0d",
                 hits_blue, hits_green, hits_red, hits_white);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
